// File: rtl/min_coin_change_defines.svh
// min_coin_change_defines.svh: assertion macros shared by the checker.
// No dependencies; included by files that carry concurrent assertions.
`ifndef MIN_COIN_CHANGE_DEFINES_SVH
`define MIN_COIN_CHANGE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define MCC_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed: %m");

// Next-cycle implication, disabled while reset is asserted
`define MCC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed: %m");

`endif

// File: rtl/mcc_pkg.sv
// mcc_pkg: shared constants, command codes and control structs for min_coin_change.
// No dependencies; imported by every module of the block.
package mcc_pkg;

    localparam int DEF_MAX_COINS  = 16;
    localparam int DEF_MAX_TARGET = 4095;

    localparam int VAL_W  = 12;
    localparam int BEST_W = 13;

    // All ones marks a sum that no coin combination reaches
    localparam logic [BEST_W-1:0] NO_WAY = {BEST_W{1'b1}};

    // Item command codes
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_SOLVE = 1'b1;

    // Controller to datapath commands
    typedef struct packed {
        logic load;    // store one coin
        logic start;   // latch target of a solve item
        logic init;    // write entry 0, reset sum and coin index
        logic issue;   // read one coin, advance coin index
        logic store;   // write entry for current sum, advance sum
        logic emit;    // load output register, clear coin list
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic in_solve;
        logic tgt_bad;
        logic coins_empty;
        logic k_last;
        logic sum_last;
        logic out_free;
    } dp_status_t;

endpackage

// File: rtl/mcc_datapath.sv
// mcc_datapath: coin store, fewest-coin table, min accumulator and output register.
// Depends on mcc_pkg; driven by mcc_ctrl through dp_cmd_t.
module mcc_datapath
    import mcc_pkg::*;
#(
    parameter int MAX_COINS  = DEF_MAX_COINS,
    parameter int MAX_TARGET = DEF_MAX_TARGET
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_command,
    input  logic [VAL_W-1:0] s_coin_value,
    input  logic [VAL_W-1:0] s_target_value,
    input  logic             m_ready,
    input  dp_cmd_t          cmd,
    output dp_status_t       status,
    output logic             m_valid,
    output logic             m_found,
    output logic [VAL_W-1:0] m_coin_count
);

    localparam int CIDX_W = (MAX_COINS > 1) ? $clog2(MAX_COINS) : 1;
    localparam int CNT_W  = $clog2(MAX_COINS + 1);
    localparam int ADDR_W = (MAX_TARGET > 1) ? $clog2(MAX_TARGET + 1) : 1;

    logic [VAL_W-1:0]  coin_mem [MAX_COINS];
    logic [BEST_W-1:0] tbl_mem  [MAX_TARGET+1];

    logic [CNT_W-1:0]  coin_total_reg, coin_total_next;
    logic [CIDX_W-1:0] k_reg;
    logic [VAL_W-1:0]  tgt_reg;
    logic [VAL_W-1:0]  sum_reg;
    logic [VAL_W-1:0]  coin_rd_reg;
    logic              a_vld_reg;
    logic [BEST_W-1:0] tbl_rd_reg;
    logic              b_vld_reg, b_vld_next;
    logic [BEST_W-1:0] best_reg, best_next;
    logic [BEST_W-1:0] final_reg;
    logic              m_valid_reg;
    logic              m_found_reg;
    logic [VAL_W-1:0]  m_count_reg;

    logic [BEST_W-1:0] cand;
    logic [BEST_W-1:0] best_acc;
    logic [VAL_W-1:0]  rd_sum;
    logic              load_ok;
    logic              found_w;
    logic [ADDR_W-1:0] wr_addr;
    logic [BEST_W-1:0] wr_data;

    // Status toward the controller
    assign status.in_solve    = (s_command == CMD_SOLVE);
    assign status.tgt_bad     = (s_target_value == '0)
                             || (32'(s_target_value) > 32'(MAX_TARGET));
    assign status.coins_empty = (coin_total_reg == '0);
    assign status.k_last      = ((CNT_W'(k_reg) + CNT_W'(1)) == coin_total_reg);
    assign status.sum_last    = (sum_reg == tgt_reg);
    assign status.out_free    = !m_valid_reg || m_ready;

    // Coin list bookkeeping
    assign load_ok = cmd.load && (s_coin_value != '0)
                  && (coin_total_reg < CNT_W'(MAX_COINS));

    always_comb begin
        coin_total_next = coin_total_reg;
        if (cmd.emit) begin
            coin_total_next = '0;
        end else if (load_ok) begin
            coin_total_next = coin_total_reg + CNT_W'(1);
        end
    end

    // Coin store: one write port, registered read
    always_ff @(posedge aclk) begin
        if (load_ok) begin
            coin_mem[CIDX_W'(coin_total_reg)] <= s_coin_value;
        end
        if (cmd.issue) begin
            coin_rd_reg <= coin_mem[k_reg];
        end
    end

    // Stage B: table read address and candidate valid
    assign rd_sum     = sum_reg - coin_rd_reg;
    assign b_vld_next = a_vld_reg && (coin_rd_reg <= sum_reg);

    // Stage C: fold one table entry into the running minimum
    always_comb begin
        cand     = tbl_rd_reg + BEST_W'(1);
        best_acc = best_reg;
        if (b_vld_reg && (tbl_rd_reg != NO_WAY) && (cand < best_reg)) begin
            best_acc = cand;
        end
    end

    always_comb begin
        best_next = best_acc;
        if (cmd.init || cmd.store) begin
            best_next = NO_WAY;
        end
    end

    // Table write selection
    assign wr_addr = cmd.init ? '0 : ADDR_W'(sum_reg);
    assign wr_data = cmd.init ? '0 : best_acc;

    // Fewest-coin table: one write, one registered read per cycle
    always_ff @(posedge aclk) begin
        if (cmd.init || cmd.store) begin
            tbl_mem[wr_addr] <= wr_data;
        end
        if (a_vld_reg) begin
            tbl_rd_reg <= tbl_mem[ADDR_W'(rd_sum)];
        end
    end

    // Result decode
    assign found_w = (final_reg != NO_WAY) && (final_reg != '0);

    // Counters, pipeline valids and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coin_total_reg <= '0;
            k_reg          <= '0;
            sum_reg        <= '0;
            a_vld_reg      <= 1'b0;
            b_vld_reg      <= 1'b0;
            best_reg       <= NO_WAY;
            m_valid_reg    <= 1'b0;
        end else begin
            coin_total_reg <= coin_total_next;
            a_vld_reg      <= cmd.issue;
            b_vld_reg      <= b_vld_next;
            best_reg       <= best_next;

            if (cmd.init || (cmd.issue && status.k_last)) begin
                k_reg <= '0;
            end else if (cmd.issue) begin
                k_reg <= k_reg + CIDX_W'(1);
            end

            if (cmd.init) begin
                sum_reg <= VAL_W'(1);
            end else if (cmd.store) begin
                sum_reg <= sum_reg + VAL_W'(1);
            end

            if (cmd.emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            tgt_reg   <= s_target_value;
            final_reg <= NO_WAY;
        end else if (cmd.store) begin
            final_reg <= best_acc;
        end
        if (cmd.emit) begin
            m_found_reg <= found_w;
            m_count_reg <= found_w ? final_reg[VAL_W-1:0] : '0;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_found      = m_found_reg;
    assign m_coin_count = m_count_reg;

endmodule

// File: rtl/mcc_ctrl.sv
// mcc_ctrl: sequencer for load and solve items of min_coin_change.
// Depends on mcc_pkg; drives mcc_datapath through dp_cmd_t.
module mcc_ctrl
    import mcc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_ISSUE,
        ST_DRAIN1,
        ST_DRAIN2,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   accept;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    // Next state and datapath commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && !status.in_solve) begin
                    cmd.load = 1'b1;
                end else if (accept) begin
                    cmd.start  = 1'b1;
                    state_next = status.tgt_bad ? ST_DONE : ST_INIT;
                end
            end
            ST_INIT: begin
                cmd.init   = 1'b1;
                state_next = status.coins_empty ? ST_DRAIN1 : ST_ISSUE;
            end
            ST_ISSUE: begin
                cmd.issue = 1'b1;
                if (status.k_last) begin
                    state_next = ST_DRAIN1;
                end
            end
            ST_DRAIN1: begin
                state_next = ST_DRAIN2;
            end
            ST_DRAIN2: begin
                cmd.store = 1'b1;
                if (status.sum_last) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = status.coins_empty ? ST_DRAIN1 : ST_ISSUE;
                end
            end
            ST_DONE: begin
                if (status.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// File: rtl/min_coin_change.sv
// min_coin_change: top level, fewest coins for a target sum (unbounded coin change).
// Depends on mcc_pkg, mcc_ctrl and mcc_datapath.
//
//   channel | ports                                      | carries
//   s_      | s_valid s_ready s_command s_coin_value     | load coin / solve item
//           | s_target_value                             |
//   m_      | m_valid m_ready m_found m_coin_count       | one result per solve
//
// A load item leaves the input side ready for the next item. A solve item with target T
// and N stored coins walks every sum from 1 to T: one table read per cycle through the
// single read port of the fewest-coin table as coins issue, then DRAIN1 and DRAIN2 per sum.
// Reset (aresetn, synchronous, active low) empties the coin list; the table needs
// no clearing since each solve writes every entry before it reads it.
// A stalled result waits in the output register; a load can still be taken then.
module min_coin_change
    import mcc_pkg::*;
#(
    parameter int MAX_COINS  = DEF_MAX_COINS,
    parameter int MAX_TARGET = DEF_MAX_TARGET
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic             s_command,
    input  logic [VAL_W-1:0] s_coin_value,
    input  logic [VAL_W-1:0] s_target_value,
    output logic             m_valid,
    input  logic             m_ready,
    output logic             m_found,
    output logic [VAL_W-1:0] m_coin_count
);

    dp_cmd_t    cmd;
    dp_status_t status;

    mcc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    mcc_datapath #(
        .MAX_COINS  (MAX_COINS),
        .MAX_TARGET (MAX_TARGET)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_command      (s_command),
        .s_coin_value   (s_coin_value),
        .s_target_value (s_target_value),
        .m_ready        (m_ready),
        .cmd            (cmd),
        .status         (status),
        .m_valid        (m_valid),
        .m_found        (m_found),
        .m_coin_count   (m_coin_count)
    );

endmodule

// File: rtl/mcc_checker.sv
// mcc_checker: port-level assertions for min_coin_change, bound to the top level.
// Depends on mcc_pkg and min_coin_change_defines.svh.
`include "min_coin_change_defines.svh"

module mcc_checker
    import mcc_pkg::*;
(
    input logic             aclk,
    input logic             aresetn,
    input logic             s_valid,
    input logic             s_ready,
    input logic             s_command,
    input logic             m_valid,
    input logic             m_ready,
    input logic             m_found,
    input logic [VAL_W-1:0] m_coin_count
);

    logic s_acc;
    assign s_acc = s_valid && s_ready;

    // A stalled result holds
    `MCC_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_found) && $stable(m_coin_count))

    // Not-found results report zero coins
    `MCC_ASSERT_NOW(a_nf_zero, aclk, aresetn, m_valid && !m_found, m_coin_count == '0)

    // A found result needs at least one coin
    `MCC_ASSERT_NOW(a_found_pos, aclk, aresetn, m_valid && m_found, m_coin_count != '0)

    // A solve item keeps the input side busy in the cycle after it is taken
    `MCC_ASSERT_NEXT(a_solve_busy, aclk, aresetn, s_acc && (s_command == CMD_SOLVE),
        !s_ready)

    // A load item leaves the input side ready in the cycle after it is taken
    `MCC_ASSERT_NEXT(a_load_1cyc, aclk, aresetn, s_acc && (s_command == CMD_LOAD),
        s_ready)

endmodule

bind min_coin_change mcc_checker u_mcc_checker (.*);

// File: tb/tb.sv
`timescale 1ns / 1ps
// tb: self-checking testbench for min_coin_change (fewest coins for a target sum).
// Depends on mcc_pkg and the min_coin_change RTL. Coin loads and solves are sent
// and every result is checked against a built-in table-fill predictor.
module tb;
    import mcc_pkg::*;

    // The limit leaves ample margin over the worst solve, 16 coins and target 4095
    localparam int unsigned CYCLE_LIMIT  = 3_000_000;
    localparam int unsigned TAIL_CYCLES  = 100;

    typedef struct packed {
        logic             found;
        logic [VAL_W-1:0] count;
    } answer_t;

    logic             aclk           = 1'b0;
    logic             aresetn        = 1'b0;
    logic             s_valid        = 1'b0;
    logic             s_ready;
    logic             s_command      = CMD_LOAD;
    logic [VAL_W-1:0] s_coin_value   = '0;
    logic [VAL_W-1:0] s_target_value = '0;
    logic             m_valid;
    logic             m_ready        = 1'b0;
    logic             m_found;
    logic [VAL_W-1:0] m_coin_count;

    // Predictor state: stored denominations and the fewest-coin table
    logic [VAL_W-1:0]  loaded_coins[$];
    logic [BEST_W-1:0] fewest[0:DEF_MAX_TARGET];
    answer_t           pending_answers[$];

    bit          steady = 1'b0;   // no idling on either side while set
    int unsigned hold_left = 0;
    int unsigned cycle_count = 0;
    int unsigned err_count = 0;
    int unsigned loads_sent = 0;
    int unsigned loads_ignored = 0;
    int unsigned solves_sent = 0;
    int unsigned results_checked = 0;

    min_coin_change dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_command      (s_command),
        .s_coin_value   (s_coin_value),
        .s_target_value (s_target_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_found        (m_found),
        .m_coin_count   (m_coin_count)
    );

    // 50 MHz clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Run-length guard
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Fewest coins for tgt over the current coin list; zero target or no way -> not found
    function automatic void fewest_coins(input logic [VAL_W-1:0] tgt,
                                         output logic fnd, output logic [VAL_W-1:0] cnt);
        logic [BEST_W-1:0] pick;
        logic [BEST_W-1:0] prev;
        fnd = 1'b0;
        cnt = '0;
        if (tgt == 0 || tgt > DEF_MAX_TARGET)
            return;
        fewest[0] = '0;
        for (int s = 1; s <= tgt; s++) begin
            pick = NO_WAY;
            foreach (loaded_coins[k]) begin
                if (loaded_coins[k] <= s) begin
                    prev = fewest[s - loaded_coins[k]];
                    if (prev != NO_WAY && prev + BEST_W'(1) < pick)
                        pick = prev + BEST_W'(1);
                end
            end
            fewest[s] = pick;
        end
        if (fewest[tgt] != NO_WAY && fewest[tgt] != 0) begin
            fnd = 1'b1;
            cnt = fewest[tgt][VAL_W-1:0];
        end
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned roll;
        if (steady)
            return 0;
        roll = $urandom_range(99);
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // Mostly small denominations, some wide ones to toggle the upper bits
    function automatic logic [VAL_W-1:0] rand_coin();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 70)
            return VAL_W'($urandom_range(20, 1));
        if (roll < 90)
            return VAL_W'($urandom_range(200, 21));
        return VAL_W'($urandom_range(4095, 201));
    endfunction

    // Large targets only with short coin lists, to keep solves short
    function automatic logic [VAL_W-1:0] rand_target(input int unsigned n_coins);
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 80)
            return VAL_W'($urandom_range(64, 1));
        if (roll < 95 || n_coins > 3)
            return VAL_W'($urandom_range(400, 65));
        return VAL_W'($urandom_range(4095, 401));
    endfunction

    // Send one item, update the predictor when it is accepted, then maybe idle
    task automatic send_item(input logic cmd, input logic [VAL_W-1:0] coin,
                             input logic [VAL_W-1:0] tgt);
        answer_t     ans;
        int unsigned gap;
        s_valid        <= 1'b1;
        s_command      <= cmd;
        s_coin_value   <= coin;
        s_target_value <= tgt;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        if (cmd == CMD_LOAD) begin
            loads_sent++;
            if (coin != 0 && loaded_coins.size() < DEF_MAX_COINS)
                loaded_coins.push_back(coin);
            else
                loads_ignored++;
        end else begin
            fewest_coins(tgt, ans.found, ans.count);
            loaded_coins.delete();
            pending_answers.push_back(ans);
            solves_sent++;
        end
        gap = pick_gap();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Stop sending until every expected result has come back
    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge aclk);
    endtask

    // Result sink stalls: mostly ready, short stalls, now and then a long one
    always @(posedge aclk) begin : sink_stall
        int unsigned roll;
        roll = $urandom_range(99);
        if (hold_left != 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (steady || roll < 65) begin
            m_ready <= 1'b1;
        end else if (roll < 92) begin
            m_ready <= 1'b0;
            hold_left = $urandom_range(2, 0);
        end else begin
            m_ready <= 1'b0;
            hold_left = $urandom_range(60, 20);
        end
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge aclk) begin : result_check
        answer_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_answers.size() == 0) begin
                err_count++;
                $display("%0t: result with nothing expected: found %0b count %0d",
                         $time, m_found, m_coin_count);
            end else begin
                want = pending_answers.pop_front();
                results_checked++;
                if (m_found !== want.found) begin
                    err_count++;
                    $display("%0t: found mismatch: expected %0b actual %0b",
                             $time, want.found, m_found);
                end
                if (m_coin_count !== want.count) begin
                    err_count++;
                    $display("%0t: coin_count mismatch: expected %0d actual %0d",
                             $time, want.count, m_coin_count);
                end
            end
        end
    end

    // Zero coin skipped, 16 coins fill the list, a 17th is dropped.
    // Target 31 needs the last stored coin, so a counted zero coin shows up.
    task automatic test_full_list();
        send_item(CMD_LOAD, '0, 12'd4095);
        for (int c = 2; c <= 30; c += 2)
            send_item(CMD_LOAD, VAL_W'(c), '0);
        send_item(CMD_LOAD, 12'd31, '0);
        send_item(CMD_LOAD, 12'd1, '0);
        send_item(CMD_SOLVE, 12'd4095, 12'd31);
    endtask

    // Zero target gives not found and still clears the list
    task automatic test_zero_target();
        send_item(CMD_LOAD, 12'd7, '0);
        send_item(CMD_SOLVE, '0, '0);
    endtask

    // Solve with nothing stored: unreachable
    task automatic test_empty_list();
        send_item(CMD_SOLVE, '0, 12'd7);
    endtask

    // Widest coin and widest target, back to back with no idling
    task automatic test_extremes();
        steady = 1'b1;
        send_item(CMD_LOAD, 12'd4095, 12'd4095);
        send_item(CMD_LOAD, 12'd1, '0);
        send_item(CMD_SOLVE, 12'd4095, 12'd4095);
        steady = 1'b0;
    endtask

    // Well-formed coin sets, each followed by a solve
    task automatic test_random_sets(input int unsigned n_sets);
        int unsigned n_coins;
        for (int i = 0; i < n_sets; i++) begin
            n_coins = $urandom_range(5, 1);
            repeat (n_coins)
                send_item(CMD_LOAD, rand_coin(), VAL_W'($urandom_range(4095, 0)));
            send_item(CMD_SOLVE, VAL_W'($urandom_range(4095, 0)), rand_target(n_coins));
        end
    endtask

    // Loose mix: zero coins, zero targets, solves on empty or odd lists
    task automatic test_random_noise(input int unsigned n_items);
        logic [VAL_W-1:0] coin;
        logic [VAL_W-1:0] tgt;
        for (int i = 0; i < n_items; i++) begin
            coin = ($urandom_range(99) < 20) ? '0 : rand_coin();
            tgt  = ($urandom_range(99) < 15) ? '0 : rand_target(loaded_coins.size());
            send_item($urandom_range(1, 0) ? CMD_SOLVE : CMD_LOAD, coin, tgt);
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        test_full_list();
        test_zero_target();
        test_empty_list();
        test_extremes();
        drain_results();

        steady = 1'b1;
        test_random_sets(5);
        steady = 1'b0;
        test_random_sets(10);
        drain_results();
        test_random_noise(15);
        send_item(CMD_SOLVE, '0, 12'd1);

        drain_results();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (pending_answers.size() != 0) begin
            err_count++;
            $display("%0t: %0d results never arrived", $time, pending_answers.size());
        end

        $display("covered %0d coin loads (%0d skipped or dropped) and %0d solves",
                 loads_sent, loads_ignored, solves_sent);
        $display("%0d results compared, %0d mismatches, %0d cycles",
                 results_checked, err_count, cycle_count);
        if (err_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

// File: sim.f
+incdir+rtl
rtl/mcc_pkg.sv
rtl/mcc_datapath.sv
rtl/mcc_ctrl.sv
rtl/min_coin_change.sv
rtl/mcc_checker.sv
tb/tb.sv
